FILE: src/oale_pkg.sv
// ----------------------------------------------------------------------------
// oale_pkg
// Shared types and constants for the ordered array list engine.
// ----------------------------------------------------------------------------
package oale_pkg;

    localparam int CAPACITY = 32;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 5;
    localparam int CNT_W    = 6;
    localparam int CMD_W    = 2;
    localparam int STAT_W   = 2;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 2'd0,
        CMD_REMOVE   = 2'd1,
        CMD_RETRIEVE = 2'd2,
        CMD_INC_ALL  = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_ctrl;

endpackage

FILE: src/oale_ctrl.sv
// ----------------------------------------------------------------------------
// oale_ctrl
// Sequencer: takes a command, runs the execute state, holds the result valid.
// ----------------------------------------------------------------------------
module oale_ctrl
    import oale_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    output logic     o_m_tvalid,
    input  logic     i_m_tready,
    output t_dp_ctrl o_dp_ctrl
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_out_valid    = r_out_valid;
        w_ready        = 1'b0;
        o_dp_ctrl.load = 1'b0;
        o_dp_ctrl.exec = 1'b0;
        // result slot drains independently of the sequencer
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                w_ready = !r_out_valid || i_m_tready;
                if (w_ready && i_s_tvalid) begin
                    o_dp_ctrl.load = 1'b1;
                    n_state        = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_dp_ctrl.exec = 1'b1;
                n_out_valid    = 1'b1;
                n_state        = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_s_tready = w_ready;
    assign o_m_tvalid = r_out_valid;

endmodule

FILE: src/oale_dp.sv
// ----------------------------------------------------------------------------
// oale_dp
// Datapath: entry register array with parallel shift, increment and read,
// item count and result register.
// ----------------------------------------------------------------------------
module oale_dp
    import oale_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_ctrl          i_dp_ctrl,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [POS_W-1:0]  i_position,
    input  logic [DATA_W-1:0] i_value,
    output logic [STAT_W-1:0] o_status,
    output logic [DATA_W-1:0] o_item,
    output logic [CNT_W-1:0]  o_count
);

    t_cmd              r_cmd;
    logic [POS_W-1:0]  r_pos;
    logic [DATA_W-1:0] r_val;
    logic [DATA_W-1:0] r_ent [CAPACITY];
    logic [DATA_W-1:0] n_ent [CAPACITY];
    logic [CNT_W-1:0]  r_len, n_len;
    t_status           r_status, n_status;
    logic [DATA_W-1:0] r_item, n_item;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  w_pos;
    logic              w_full;

    assign w_pos  = {1'b0, r_pos};
    assign w_full = (r_len == CNT_W'(CAPACITY));

    always_ff @(posedge i_clk) begin
        if (i_dp_ctrl.load) begin
            r_cmd <= t_cmd'(i_command);
            r_pos <= i_position;
            r_val <= i_value;
        end
    end

    always_comb begin
        n_ent    = r_ent;
        n_len    = r_len;
        n_status = STAT_OK;
        n_item   = '0;
        unique case (r_cmd)
            CMD_INSERT: begin
                if (w_full) begin
                    n_status = STAT_FULL;
                end else if (w_pos > r_len) begin
                    n_status = STAT_RANGE;
                end else begin
                    for (int i = 1; i < CAPACITY; i++) begin
                        if (CNT_W'(i) > w_pos && CNT_W'(i) <= r_len) begin
                            n_ent[i] = r_ent[i-1];
                        end
                    end
                    n_ent[r_pos] = r_val;
                    n_len        = r_len + CNT_W'(1);
                end
            end
            CMD_REMOVE: begin
                if (w_pos >= r_len) begin
                    n_status = STAT_RANGE;
                end else begin
                    for (int i = 0; i < CAPACITY - 1; i++) begin
                        if (CNT_W'(i) >= w_pos && CNT_W'(i + 1) < r_len) begin
                            n_ent[i] = r_ent[i+1];
                        end
                    end
                    n_len = r_len - CNT_W'(1);
                end
            end
            CMD_RETRIEVE: begin
                if (w_pos >= r_len) begin
                    n_status = STAT_RANGE;
                end else begin
                    n_item = r_ent[r_pos];
                end
            end
            CMD_INC_ALL: begin
                for (int i = 0; i < CAPACITY; i++) begin
                    if (CNT_W'(i) < r_len) begin
                        n_ent[i] = r_ent[i] + DATA_W'(1);
                    end
                end
            end
            default: begin
                n_status = STAT_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_ctrl.exec) begin
            r_ent <= n_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_dp_ctrl.exec) begin
            r_len <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_ctrl.exec) begin
            r_status <= n_status;
            r_item   <= n_item;
            r_count  <= n_len;
        end
    end

    assign o_status = r_status;
    assign o_item   = r_item;
    assign o_count  = r_count;

endmodule

FILE: src/ordered_array_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_array_list_engine
// Ordered list of signed 32-bit items in a 32-entry register store with
// insert, remove, retrieve and increment-all commands.
// ----------------------------------------------------------------------------
// the command is registered on transfer; the execute state registers result and valid
// a new command is accepted only in idle, while the result slot is empty or draining
// the whole list shifts or increments in parallel inside the execute cycle
// reset: synchronous, clears the item count and handshake state; entries are
// left as they are and are only read below the count
module ordered_array_list_engine
    import oale_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,   // command[1:0], position[6:2], value[38:7], pad
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata    // status[1:0], item[33:2], count[39:34]
);

    t_dp_ctrl          w_dp_ctrl;
    logic [STAT_W-1:0] w_status;
    logic [DATA_W-1:0] w_item;
    logic [CNT_W-1:0]  w_count;

    oale_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_dp_ctrl  (w_dp_ctrl)
    );

    oale_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dp_ctrl  (w_dp_ctrl),
        .i_command  (i_s_tdata[1:0]),
        .i_position (i_s_tdata[6:2]),
        .i_value    (i_s_tdata[38:7]),
        .o_status   (w_status),
        .o_item     (w_item),
        .o_count    (w_count)
    );

    assign o_m_tdata = {w_count, w_item, w_status};

endmodule
